### rtl/core/assert_macros.svh
// Assertion macros used by the RTL of the button qualifier.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checks a property on every rising clock edge, during reset too.
`define ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

### rtl/core/bdlp_pkg.sv
// Types and constants of the button debounce and long-press qualifier.
`default_nettype none

package bdlp_pkg;

   localparam int unsigned COUNT_W = 16;

   localparam logic [COUNT_W-1:0] BOUNCE_RESET = 16'd100;
   localparam logic [COUNT_W-1:0] HOLD_RESET   = 16'd700;

   localparam logic [1:0] ST_NONE    = 2'd0;
   localparam logic [1:0] ST_PRESSED = 2'd1;
   localparam logic [1:0] ST_HELD    = 2'd2;

   localparam logic [1:0] PHASE_CODE_IDLE   = 2'd0;
   localparam logic [1:0] PHASE_CODE_SETTLE = 2'd1;
   localparam logic [1:0] PHASE_CODE_DOWN   = 2'd2;

   localparam logic REG_BOUNCE = 1'b0;
   localparam logic REG_HOLD   = 1'b1;

   localparam logic CMD_TICK = 1'b0;
   localparam logic CMD_EDGE = 1'b1;

   typedef enum logic [2:0] {
      PH_IDLE   = 3'b001,
      PH_SETTLE = 3'b010,
      PH_DOWN   = 3'b100
   } phase_type;

   typedef struct packed {
      logic       edge_armed;
      logic [1:0] key_phase;
      logic [1:0] press_status;
   } result_type;

   function automatic logic [1:0] phase_code(input phase_type ph);
      logic [1:0] code;
      unique case (ph)
         PH_IDLE:   code = PHASE_CODE_IDLE;
         PH_SETTLE: code = PHASE_CODE_SETTLE;
         PH_DOWN:   code = PHASE_CODE_DOWN;
         default:   code = PHASE_CODE_IDLE;
      endcase
      return code;
   endfunction

endpackage

`default_nettype wire

### rtl/core/button_debounce_long_press.sv
// An accepted item shows its result on rsp in the next cycle.
// One item per cycle while rsp_tready is high; the whole state update is one pass of logic
// between the state registers and the result register.
// A result waiting on rsp does not block the next item while rsp_tready is high.
// Reset is synchronous and active high: idle, armed, status none, counters zero,
// bounce and hold registers at 100 and 700 ticks, no result pending.
`include "assert_macros.svh"
`default_nettype none

module button_debounce_long_press
   import bdlp_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_tvalid,
   output logic                    req_tready,
   input  wire logic [7:0]         req_tdata,   // [0] pin_level, [7:1] zero
   input  wire logic               req_tuser,   // [0] cmd
   output logic                    rsp_tvalid,
   input  wire logic               rsp_tready,
   output logic [7:0]              rsp_tdata,   // [1:0] press_status, [3:2] key_phase,
                                                // [4] edge_armed, [7:5] zero
   input  wire logic               csr_we,
   input  wire logic               csr_index,
   input  wire logic [COUNT_W-1:0] csr_wdata
);

   logic [COUNT_W-1:0] bounce_ticks_ff, bounce_ticks_in;
   logic [COUNT_W-1:0] hold_ticks_ff, hold_ticks_in;
   phase_type          phase_ff, phase_in;
   logic [COUNT_W-1:0] settle_count_ff, settle_count_in;
   logic [COUNT_W-1:0] hold_count_ff, hold_count_in;
   logic [1:0]         status_ff, status_in;
   logic               armed_ff, armed_in;
   logic               rsp_valid_ff, rsp_valid_in;
   result_type         result_ff, result_in;
   logic               req_fire;
   logic               pin_high;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_fire   = req_tvalid && req_tready;
   assign pin_high   = req_tdata[0];

   always_comb begin
      bounce_ticks_in = bounce_ticks_ff;
      hold_ticks_in   = hold_ticks_ff;
      if (csr_we) begin
         unique case (csr_index)
            REG_BOUNCE: bounce_ticks_in = csr_wdata;
            REG_HOLD:   hold_ticks_in   = csr_wdata;
            default:    ;
         endcase
      end
   end

   always_comb begin
      phase_in        = phase_ff;
      settle_count_in = settle_count_ff;
      hold_count_in   = hold_count_ff;
      status_in       = status_ff;
      armed_in        = armed_ff;
      if (req_fire) begin
         if (req_tuser == CMD_EDGE) begin
            if (phase_ff == PH_IDLE && armed_ff) begin
               armed_in        = 1'b0;
               phase_in        = PH_SETTLE;
               settle_count_in = bounce_ticks_ff;
            end
         end else begin
            unique case (phase_ff)
               PH_SETTLE: begin
                  if (settle_count_ff != '0) begin
                     settle_count_in = settle_count_ff - COUNT_W'(1);
                  end else if (pin_high) begin
                     phase_in      = PH_DOWN;
                     status_in     = ST_PRESSED;
                     hold_count_in = hold_ticks_ff;
                  end else begin
                     phase_in = PH_IDLE;
                     armed_in = 1'b1;
                  end
               end
               PH_DOWN: begin
                  if (!pin_high) begin
                     phase_in  = PH_IDLE;
                     status_in = ST_NONE;
                     armed_in  = 1'b1;
                  end else if (hold_count_ff != '0) begin
                     hold_count_in = hold_count_ff - COUNT_W'(1);
                  end else begin
                     status_in = ST_HELD;
                  end
               end
               PH_IDLE: ;
               default: ;
            endcase
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      result_in    = result_ff;
      if (req_fire) begin
         rsp_valid_in           = 1'b1;
         result_in.press_status = status_in;
         result_in.key_phase    = phase_code(phase_in);
         result_in.edge_armed   = armed_in;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bounce_ticks_ff <= BOUNCE_RESET;
         hold_ticks_ff   <= HOLD_RESET;
         phase_ff        <= PH_IDLE;
         settle_count_ff <= '0;
         hold_count_ff   <= '0;
         status_ff       <= ST_NONE;
         armed_ff        <= 1'b1;
         rsp_valid_ff    <= 1'b0;
      end else begin
         bounce_ticks_ff <= bounce_ticks_in;
         hold_ticks_ff   <= hold_ticks_in;
         phase_ff        <= phase_in;
         settle_count_ff <= settle_count_in;
         hold_count_ff   <= hold_count_in;
         status_ff       <= status_in;
         armed_ff        <= armed_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      result_ff <= result_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, result_ff};

   // The edge-armed flag is set exactly when the key is idle.
   `ASSERT_CLK(a_armed_idle, (armed_ff == (phase_ff == PH_IDLE)), "armed differs from idle phase")
   // A nonzero status is only reported while the key is down.
   `ASSERT_CLK(a_status_down, ((status_ff != ST_NONE) == (phase_ff == PH_DOWN)), "status out of phase")
   // An accepted edge while idle starts settling with the bounce count.
   `ASSERT_CLK(a_edge_load, (req_fire && req_tuser == CMD_EDGE && phase_ff == PH_IDLE |=> phase_ff == PH_SETTLE && settle_count_ff == $past(bounce_ticks_ff)), "edge did not start settling")
   // Every accepted item leaves a result pending in the next cycle.
   `ASSERT_ALWAYS(a_fire_result, (!reset && req_fire |=> reset || rsp_valid_ff), "accepted item gave no result")

endmodule

`default_nettype wire
